[design/epsp_pkg.sv]
`default_nettype none

package epsp_pkg;

    localparam int POS_W      = 16;
    localparam int TGT_W      = 16;
    localparam int PULSE_W    = 11;
    localparam int GAIN_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam int POS_WIDE = (POS_W > TGT_W) ? POS_W : TGT_W;
    // target - count, exact
    localparam int ERR_W    = POS_WIDE + 1;
    // zero-extended (non-negative) gain times signed position change
    localparam int D_W      = POS_W + GAIN_W + 1;
    localparam int U_W      = ((ERR_W > D_W) ? ERR_W : D_W) + 1;
    localparam int V_W      = ((U_W > PULSE_W + 1) ? U_W : PULSE_W + 1) + 1;

    localparam logic [GAIN_W-1:0]  RST_GAIN       = GAIN_W'(16);
    localparam logic [PULSE_W-1:0] RST_NEUTRAL_UP = PULSE_W'(755);
    localparam logic [PULSE_W-1:0] RST_NEUTRAL_CT = PULSE_W'(745);
    localparam logic [PULSE_W-1:0] RST_NEUTRAL_DN = PULSE_W'(730);
    localparam logic [PULSE_W-1:0] RST_PULSE_MAX  = PULSE_W'(1080);
    localparam logic [PULSE_W-1:0] RST_PULSE_MIN  = PULSE_W'(406);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DERIV_GAIN   = 3'd0,
        CFG_P_QUARTER    = 3'd1,
        CFG_DIR_INVERT   = 3'd2,
        CFG_NEUTRAL_UP   = 3'd3,
        CFG_NEUTRAL_CT   = 3'd4,
        CFG_NEUTRAL_DN   = 3'd5,
        CFG_PULSE_MAX    = 3'd6,
        CFG_PULSE_MIN    = 3'd7
    } epsp_cfg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  deriv_gain;
        logic               p_quarter;
        logic               dir_invert;
        logic [PULSE_W-1:0] neutral_up;
        logic [PULSE_W-1:0] neutral_center;
        logic [PULSE_W-1:0] neutral_down;
        logic [PULSE_W-1:0] pulse_max;
        logic [PULSE_W-1:0] pulse_min;
    } epsp_cfg_t;

    // low target-width bits of the count, zero-extended if the count is narrower
    function automatic logic [TGT_W-1:0] pos_to_meas(input logic [POS_W-1:0] v);
        logic [POS_WIDE-1:0] wide;
        wide = POS_WIDE'(v);
        return wide[TGT_W-1:0];
    endfunction

endpackage

`default_nettype wire

[design/epsp_item_if.sv]
`default_nettype none

interface epsp_item_if import epsp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic                    phase_a;
    logic                    phase_b;
    logic signed [TGT_W-1:0] target;

    modport source (output valid, output kind, output phase_a, output phase_b,
                    output target, input ready);
    modport sink   (input valid, input kind, input phase_a, input phase_b,
                    input target, output ready);
endinterface

`default_nettype wire

[design/epsp_result_if.sv]
`default_nettype none

interface epsp_result_if import epsp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [PULSE_W-1:0]      pulse_width;
    logic signed [TGT_W-1:0] measured_position;

    modport source (output valid, output pulse_width, output measured_position,
                    input ready);
    modport sink   (input valid, input pulse_width, input measured_position,
                    output ready);
endinterface

`default_nettype wire

[design/epsp_cfg_if.sv]
`default_nettype none

interface epsp_cfg_if import epsp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/epsp_cfg_regs.sv]
`default_nettype none

module epsp_cfg_regs
    import epsp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    epsp_cfg_if.sink    cfg,
    output epsp_cfg_t   cfg_regs
);

    epsp_cfg_t cfg_reg;
    epsp_cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_regs  = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (epsp_cfg_idx_t'(cfg.index))
                CFG_DERIV_GAIN: cfg_next.deriv_gain     = cfg.data[GAIN_W-1:0];
                CFG_P_QUARTER:  cfg_next.p_quarter      = cfg.data[0];
                CFG_DIR_INVERT: cfg_next.dir_invert     = cfg.data[0];
                CFG_NEUTRAL_UP: cfg_next.neutral_up     = cfg.data[PULSE_W-1:0];
                CFG_NEUTRAL_CT: cfg_next.neutral_center = cfg.data[PULSE_W-1:0];
                CFG_NEUTRAL_DN: cfg_next.neutral_down   = cfg.data[PULSE_W-1:0];
                CFG_PULSE_MAX:  cfg_next.pulse_max      = cfg.data[PULSE_W-1:0];
                CFG_PULSE_MIN:  cfg_next.pulse_min      = cfg.data[PULSE_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deriv_gain     <= RST_GAIN;
            cfg_reg.p_quarter      <= 1'b0;
            cfg_reg.dir_invert     <= 1'b0;
            cfg_reg.neutral_up     <= RST_NEUTRAL_UP;
            cfg_reg.neutral_center <= RST_NEUTRAL_CT;
            cfg_reg.neutral_down   <= RST_NEUTRAL_DN;
            cfg_reg.pulse_max      <= RST_PULSE_MAX;
            cfg_reg.pulse_min      <= RST_PULSE_MIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[design/epsp_law.sv]
`default_nettype none

module epsp_law
    import epsp_pkg::*;
(
    input  wire epsp_cfg_t                cfg_regs,
    input  wire logic signed [ERR_W-1:0]  p_term,
    input  wire logic signed [POS_W-1:0]  delta,
    output logic [PULSE_W-1:0]            pulse_width
);

    logic signed [GAIN_W:0]      gain_s;
    logic signed [D_W-1:0]       d_term;
    logic signed [U_W-1:0]       u;
    logic [PULSE_W-1:0]          offset;
    logic signed [V_W-1:0]       v;
    logic signed [V_W-1:0]       pmax_s;
    logic signed [V_W-1:0]       pmin_s;

    assign gain_s = {1'b0, cfg_regs.deriv_gain};
    assign d_term = gain_s * delta;
    assign u      = U_W'(p_term) - U_W'(d_term);

    always_comb
    begin
        if (u == '0)
            offset = cfg_regs.neutral_center;
        else if (u[U_W-1])
            offset = cfg_regs.neutral_down;
        else
            offset = cfg_regs.neutral_up;
    end

    assign v      = V_W'(u) + V_W'(signed'({1'b0, offset}));
    assign pmax_s = V_W'(signed'({1'b0, cfg_regs.pulse_max}));
    assign pmin_s = V_W'(signed'({1'b0, cfg_regs.pulse_min}));

    // max wins over min when the limits cross
    always_comb
    begin
        if (v > pmax_s)
            pulse_width = cfg_regs.pulse_max;
        else if (v < pmin_s)
            pulse_width = cfg_regs.pulse_min;
        else
            pulse_width = v[PULSE_W-1:0];
    end

endmodule

`default_nettype wire

[design/encoder_pd_servo_pulse_controller.sv]
// Throughput: 1 item per cycle unless the result stalls. Encoder edges update
// the count at acceptance and give no result. A control tick is registered in
// stage 1, which forms error and position change, then in the result register
// by stage 2, which does the gain multiply, neutral offset and clamp.
// Reset (rst_n low, asynchronous): count and last position clear to zero,
// registers return to their defaults, pipeline empties.
`default_nettype none

module encoder_pd_servo_pulse_controller
    import epsp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    epsp_item_if.sink    item,
    epsp_result_if.source result,
    epsp_cfg_if.sink     cfg
);

    epsp_cfg_t cfg_regs;

    logic [POS_W-1:0]          count_reg;
    logic [POS_W-1:0]          count_next;
    logic [POS_W-1:0]          last_reg;
    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    logic signed [ERR_W-1:0]   p_reg;
    logic signed [POS_W-1:0]   delta_reg;
    logic [TGT_W-1:0]          s1_meas_reg;
    logic                      res_valid_reg;
    logic                      res_valid_next;
    logic [PULSE_W-1:0]        res_pulse_reg;
    logic [TGT_W-1:0]          res_meas_reg;

    logic                      s1_adv;
    logic                      acc;
    logic                      step_up;
    logic signed [ERR_W-1:0]   err;
    logic signed [ERR_W-1:0]   p_next;
    logic [PULSE_W-1:0]        pulse_calc;

    epsp_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_regs (cfg_regs)
    );

    assign s1_adv     = !res_valid_reg || result.ready;
    assign item.ready = !s1_valid_reg || s1_adv;
    assign acc        = item.valid && item.ready;

    assign step_up = item.phase_a ^ item.phase_b ^ cfg_regs.dir_invert;

    always_comb
    begin
        count_next = count_reg;
        if (acc && !item.kind)
            count_next = step_up ? count_reg + POS_W'(1) : count_reg - POS_W'(1);
    end

    assign err = ERR_W'(item.target) - ERR_W'(signed'(count_reg));

    // divide by four toward zero: bias negatives before the shift
    always_comb
    begin
        if (!cfg_regs.p_quarter)
            p_next = err;
        else if (err[ERR_W-1])
            p_next = (err + ERR_W'(3)) >>> 2;
        else
            p_next = err >>> 2;
    end

    always_comb
    begin
        if (acc && item.kind)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    assign res_valid_next = s1_adv ? s1_valid_reg : res_valid_reg;

    epsp_law u_law (
        .cfg_regs    (cfg_regs),
        .p_term      (p_reg),
        .delta       (delta_reg),
        .pulse_width (pulse_calc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            last_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (acc && item.kind)
                last_reg <= count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && item.kind)
        begin
            p_reg       <= p_next;
            delta_reg   <= signed'(count_reg - last_reg);
            s1_meas_reg <= pos_to_meas(count_reg);
        end
        if (s1_adv && s1_valid_reg)
        begin
            res_pulse_reg <= pulse_calc;
            res_meas_reg  <= s1_meas_reg;
        end
    end

    assign result.valid             = res_valid_reg;
    assign result.pulse_width       = res_pulse_reg;
    assign result.measured_position = signed'(res_meas_reg);

endmodule

`default_nettype wire

[design/epsp_checker.sv]
`default_nettype none

module epsp_checker
    import epsp_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               in_kind,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [PULSE_W-1:0] out_pulse,
    input wire logic [TGT_W-1:0]   out_meas
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(out_pulse) && $stable(out_meas))
        else $error("result changed while stalled");

    // every accepted tick has a result on show once past stage 1 and the result register
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_kind |-> ##2 out_valid)
        else $error("tick gave no result");

    // an empty output stage never back-pressures the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // an edge seen in reset leaves the output empty
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid after reset");

endmodule

bind encoder_pd_servo_pulse_controller epsp_checker u_epsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_kind   (item.kind),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_pulse (result.pulse_width),
    .out_meas  (result.measured_position)
);

`default_nettype wire

[tb/tb_encoder_pd_servo_pulse_controller.sv]
`timescale 1ns / 100ps

module tb_encoder_pd_servo_pulse_controller;
    import epsp_pkg::*;

    typedef struct packed {
        logic                    kind;
        logic                    phase_a;
        logic                    phase_b;
        logic signed [TGT_W-1:0] target;
    } motion_item_t;

    typedef struct packed {
        logic [PULSE_W-1:0]      pulse_width;
        logic signed [TGT_W-1:0] position;
    } pulse_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    epsp_item_if   item_bus ();
    epsp_result_if result_bus ();
    epsp_cfg_if    cfg_bus ();

    encoder_pd_servo_pulse_controller dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    motion_item_t  pending_items[$];
    pulse_result_t pulse_expect[$];

    // controller model state
    epsp_cfg_t               servo_cfg;
    logic signed [POS_W-1:0] enc_count;
    logic signed [POS_W-1:0] tick_position;
    // count as the stimulus expects it once every queued item is taken
    logic signed [POS_W-1:0] gen_count;

    int mismatch_count = 0;
    bit item_taken     = 1'b0;
    bit quiet          = 1'b0;
    bit hold_request   = 1'b0;
    bit rx_hold        = 1'b0;
    int tx_gap         = 0;
    int rx_gap         = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic advance_channel(input motion_item_t it);
        logic                    step_up;
        logic signed [POS_W-1:0] moved;
        int                      err;
        int                      prop;
        int                      deriv;
        int                      drive;
        int                      width;
        pulse_result_t           res;
        if (!it.kind)
        begin
            step_up = (it.phase_a ^ it.phase_b) ^ servo_cfg.dir_invert;
            enc_count = step_up ? enc_count + POS_W'(1) : enc_count - POS_W'(1);
        end
        else
        begin
            err = int'(it.target) - int'(enc_count);
            prop = servo_cfg.p_quarter ? err / 4 : err;
            // wrapped difference, so a wrap between ticks is a small step
            moved = enc_count - tick_position;
            deriv = int'(servo_cfg.deriv_gain) * int'(moved);
            drive = prop - deriv;
            tick_position = enc_count;
            if (drive > 0)
                width = drive + int'(servo_cfg.neutral_up);
            else if (drive == 0)
                width = int'(servo_cfg.neutral_center);
            else
                width = drive + int'(servo_cfg.neutral_down);
            // max wins when the limits cross
            if (width > int'(servo_cfg.pulse_max))
                width = int'(servo_cfg.pulse_max);
            else if (width < int'(servo_cfg.pulse_min))
                width = int'(servo_cfg.pulse_min);
            res.pulse_width = width[PULSE_W-1:0];
            res.position = enc_count;
            pulse_expect.push_back(res);
        end
    endtask

    // sender
    always @(negedge clk)
    begin
        motion_item_t head;
        if (rst_n && (!item_bus.valid || item_taken))
        begin
            item_taken = 1'b0;
            if (tx_gap > 0)
            begin
                tx_gap--;
                item_bus.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                head = pending_items.pop_front();
                item_bus.kind    <= head.kind;
                item_bus.phase_a <= head.phase_a;
                item_bus.phase_b <= head.phase_b;
                item_bus.target  <= head.target;
                item_bus.valid   <= 1'b1;
                if (!quiet && $urandom_range(0, 4) == 0)
                    tx_gap = $urandom_range(1, 6);
            end
            else
            begin
                item_bus.valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        bit idle;
        idle = 1'b0;
        if (rx_gap > 0)
        begin
            rx_gap--;
            idle = 1'b1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            rx_gap = $urandom_range(1, 6) - 1;
            idle = 1'b1;
        end
        result_bus.ready <= rst_n && !idle && !rx_hold;
    end

    // long receiver hold-off so the pipeline backs up into the input
    initial
    begin
        wait (hold_request);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (40) @(posedge clk);
        rx_hold = 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        motion_item_t  took;
        pulse_result_t want;
        if (rst_n)
        begin
            if (item_bus.valid && item_bus.ready)
            begin
                took.kind    = item_bus.kind;
                took.phase_a = item_bus.phase_a;
                took.phase_b = item_bus.phase_b;
                took.target  = item_bus.target;
                advance_channel(took);
                item_taken = 1'b1;
            end
            if (result_bus.valid && result_bus.ready)
            begin
                if (pulse_expect.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: pulse %0d position %0d",
                                 result_bus.pulse_width, result_bus.measured_position);
                end
                else
                begin
                    want = pulse_expect.pop_front();
                    if (want.pulse_width !== result_bus.pulse_width ||
                        want.position !== result_bus.measured_position)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected pulse %0d pos %0d, got %0d pos %0d",
                                     want.pulse_width, want.position,
                                     result_bus.pulse_width, result_bus.measured_position);
                    end
                end
            end
        end
    end

    task automatic write_reg(input epsp_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        cfg_bus.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        case (idx)
            CFG_DERIV_GAIN: servo_cfg.deriv_gain     = value[GAIN_W-1:0];
            CFG_P_QUARTER:  servo_cfg.p_quarter      = value[0];
            CFG_DIR_INVERT: servo_cfg.dir_invert     = value[0];
            CFG_NEUTRAL_UP: servo_cfg.neutral_up     = value[PULSE_W-1:0];
            CFG_NEUTRAL_CT: servo_cfg.neutral_center = value[PULSE_W-1:0];
            CFG_NEUTRAL_DN: servo_cfg.neutral_down   = value[PULSE_W-1:0];
            CFG_PULSE_MAX:  servo_cfg.pulse_max      = value[PULSE_W-1:0];
            CFG_PULSE_MIN:  servo_cfg.pulse_min      = value[PULSE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_all(input int gain, input int quarter, input int invert,
                           input int nup, input int nct, input int ndn,
                           input int pmax, input int pmin);
        write_reg(CFG_DERIV_GAIN, CFG_DATA_W'(gain));
        write_reg(CFG_P_QUARTER, CFG_DATA_W'(quarter));
        write_reg(CFG_DIR_INVERT, CFG_DATA_W'(invert));
        write_reg(CFG_NEUTRAL_UP, CFG_DATA_W'(nup));
        write_reg(CFG_NEUTRAL_CT, CFG_DATA_W'(nct));
        write_reg(CFG_NEUTRAL_DN, CFG_DATA_W'(ndn));
        write_reg(CFG_PULSE_MAX, CFG_DATA_W'(pmax));
        write_reg(CFG_PULSE_MIN, CFG_DATA_W'(pmin));
    endtask

    // wait until every item is taken and every result is in, then let the
    // pipeline settle
    task automatic drain();
        while (pending_items.size() != 0 || item_bus.valid || pulse_expect.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        gen_count = enc_count;
    endtask

    task automatic push_edge(input logic pa, input logic pb);
        motion_item_t it;
        it.kind    = 1'b0;
        it.phase_a = pa;
        it.phase_b = pb;
        it.target  = TGT_W'($urandom);
        if ((pa ^ pb) ^ servo_cfg.dir_invert)
            gen_count = gen_count + POS_W'(1);
        else
            gen_count = gen_count - POS_W'(1);
        pending_items.push_back(it);
    endtask

    task automatic push_tick(input logic signed [TGT_W-1:0] tgt);
        motion_item_t it;
        it.kind    = 1'b1;
        it.phase_a = 1'($urandom);
        it.phase_b = 1'($urandom);
        it.target  = tgt;
        pending_items.push_back(it);
    endtask

    task automatic push_random(input int tick_pct);
        if ($urandom_range(0, 99) < tick_pct)
        begin
            if ($urandom_range(0, 3) == 0)
                push_tick(TGT_W'($urandom));
            else
                push_tick(TGT_W'(int'(gen_count) + int'($urandom_range(0, 80)) - 40));
        end
        else
        begin
            push_edge(1'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        item_bus.valid   = 1'b0;
        item_bus.kind    = 1'b0;
        item_bus.phase_a = 1'b0;
        item_bus.phase_b = 1'b0;
        item_bus.target  = '0;
        result_bus.ready = 1'b0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = CFG_DERIV_GAIN;
        cfg_bus.data     = '0;

        servo_cfg.deriv_gain     = RST_GAIN;
        servo_cfg.p_quarter      = 1'b0;
        servo_cfg.dir_invert     = 1'b0;
        servo_cfg.neutral_up     = RST_NEUTRAL_UP;
        servo_cfg.neutral_center = RST_NEUTRAL_CT;
        servo_cfg.neutral_down   = RST_NEUTRAL_DN;
        servo_cfg.pulse_max      = RST_PULSE_MAX;
        servo_cfg.pulse_min      = RST_PULSE_MIN;
        enc_count     = '0;
        tick_position = '0;
        gen_count     = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset defaults: neutral, all four phase pairs, wrap below zero,
        // targets at both ends, one step each side of zero, a D kick
        push_tick(TGT_W'(0));
        push_edge(1'b0, 1'b0);
        push_edge(1'b0, 1'b1);
        push_edge(1'b1, 1'b0);
        push_edge(1'b1, 1'b1);
        push_edge(1'b0, 1'b0);
        push_tick(TGT_W'(32767));
        push_tick(TGT_W'(-32768));
        push_tick(TGT_W'(0));
        push_tick(TGT_W'(-2));
        push_edge(1'b0, 1'b1);
        push_edge(1'b1, 1'b0);
        push_tick(TGT_W'(1));
        drain();

        // quarter P and inverted direction, truncation toward zero both ways
        write_reg(CFG_P_QUARTER, CFG_DATA_W'(1));
        write_reg(CFG_DIR_INVERT, CFG_DATA_W'(1));
        push_edge(1'b0, 1'b1);
        push_edge(1'b0, 1'b0);
        push_tick(TGT_W'(gen_count + 3));
        push_tick(TGT_W'(gen_count - 3));
        push_tick(TGT_W'(gen_count + 5));
        push_tick(TGT_W'(gen_count - 5));
        push_tick(TGT_W'(gen_count + 4));
        push_tick(TGT_W'(gen_count - 4));
        push_tick(TGT_W'(32767));
        drain();

        // full gain, count stepping up and back between ticks
        set_all(255, 0, 0, 755, 745, 730, 2047, 0);
        repeat (20) push_edge(1'b0, 1'b1);
        repeat (8)
        begin
            push_tick(TGT_W'(int'(gen_count) + int'($urandom_range(0, 6)) - 3));
            push_edge(1'b1, 1'b0);
        end
        push_tick(TGT_W'(32767));
        push_tick(TGT_W'(-32768));
        repeat (6)
        begin
            push_edge(1'b0, 1'b0);
            push_tick(gen_count);
        end
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: hold_request = 1'b1;
                1: set_all(255, 1, 1, 2047, 2047, 2047, 2047, 0);
                2: set_all(0, 0, 0, 0, 0, 0, 0, 0);
                3: set_all($urandom_range(0, 255), $urandom_range(0, 1),
                           $urandom_range(0, 1), $urandom_range(0, 2047),
                           $urandom_range(0, 2047), $urandom_range(0, 2047), 500, 1500);
                4: set_all($urandom_range(0, 255), $urandom_range(0, 1),
                           $urandom_range(0, 1), $urandom_range(0, 2047),
                           $urandom_range(0, 2047), $urandom_range(0, 2047),
                           $urandom_range(0, 2047), $urandom_range(0, 2047));
                default:
                begin
                    set_all($urandom_range(0, 32), $urandom_range(0, 1),
                            $urandom_range(0, 1), 755, 745, 730, 1080, 406);
                    quiet = 1'b1;
                end
            endcase
            repeat (140) push_random(ph == 0 ? 60 : 35);
            drain();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
